// ===== rtl/tlg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_pkg
// Shared constants, types and the quarter-wave sine table for the turtle
// line generator.
// ----------------------------------------------------------------------------
package tlg_pkg;

  // Stack of saved poses
  localparam int STACK_DEPTH = 16;
  localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
  localparam int SIDX_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Quarter-wave sine table
  localparam int SINE_TABLE_BITS = 8;
  localparam int QUARTER_N       = 1 << SINE_TABLE_BITS;
  localparam int ROUND_HALF      = 1 << (13 - SINE_TABLE_BITS);
  localparam logic [SINE_TABLE_BITS:0] QUARTER_IDX = (SINE_TABLE_BITS + 1)'(QUARTER_N);
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [15:0] QUARTER_TURN = 16'h4000;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Symbol codes
  localparam logic [7:0] SYM_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] SYM_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] SYM_PUSH  = 8'h5B;  // '['
  localparam logic [7:0] SYM_POP   = 8'h5D;  // ']'

  // Register reset values
  localparam logic [15:0] TURN_ANGLE_RESET  = 16'd4005;
  localparam logic [15:0] STEP_LENGTH_RESET = 16'd256;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TURN_ANGLE     = 3'd0,
    REG_STEP_LENGTH    = 3'd1,
    REG_ORIGIN_X       = 3'd2,
    REG_ORIGIN_Y       = 3'd3,
    REG_ORIGIN_HEADING = 3'd4
  } reg_index_t;

  // Classified command
  typedef enum logic [2:0] {
    CMD_FORWARD,
    CMD_TURN_POS,
    CMD_TURN_NEG,
    CMD_PUSH,
    CMD_POP
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic restart;
  } cmd_item_t;

  // Trig value as sign and Q1.15 magnitude
  typedef struct packed {
    logic        neg;
    logic [15:0] mag;
  } trig_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               fault;
    logic               take;
  } back_status_t;

  typedef logic [15:0] sine_tab_t [QUARTER_N + 1];

  // Integer Taylor series, evaluated at elaboration
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    for (int k = 0; k <= QUARTER_N; k++) begin
      x    = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
      term = x;
      sum  = x;
      for (int n = 1; n <= 8; n++) begin
        term = (((term * x) >> 30) * x) >> 30;
        case (n)
          1:       term = term / 6;
          2:       term = term / 20;
          3:       term = term / 42;
          4:       term = term / 72;
          5:       term = term / 110;
          6:       term = term / 156;
          7:       term = term / 210;
          default: term = term / 272;
        endcase
        if (n % 2 == 1) sum = sum - term;
        else            sum = sum + term;
      end
      tab[k] = 16'((sum + 64'd16384) >> 15);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // Signed sine of a binary angle
  function automatic trig_t sine_lookup(input logic [15:0] h);
    logic [14:0]              pos_r;
    logic [SINE_TABLE_BITS:0] idx;
    trig_t                    t;
    pos_r = {1'b0, h[13:0]} + 15'(ROUND_HALF);
    idx   = pos_r[14:14-SINE_TABLE_BITS];
    t.mag = h[14] ? SINE_TAB[QUARTER_IDX - idx] : SINE_TAB[idx];
    t.neg = h[15];
    return t;
  endfunction

endpackage

// ===== rtl/tlg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_front
// Input side: takes symbol items and classifies them into commands for
// the command queue.
// ----------------------------------------------------------------------------
module tlg_front import tlg_pkg::*; (
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] symbol,
  input  logic       restart,
  input  logic       queue_full,
  output logic       queue_write,
  output cmd_item_t  queue_item
);

  // Room in the queue means an item can be taken
  assign in_ready    = !queue_full;
  assign queue_write = in_valid && !queue_full;

  // Symbol decoder
  always_comb begin
    queue_item.restart = restart;
    unique case (symbol)
      SYM_PLUS:  queue_item.cmd = CMD_TURN_POS;
      SYM_MINUS: queue_item.cmd = CMD_TURN_NEG;
      SYM_PUSH:  queue_item.cmd = CMD_PUSH;
      SYM_POP:   queue_item.cmd = CMD_POP;
      default:   queue_item.cmd = CMD_FORWARD;
    endcase
  end

endmodule

// ===== rtl/tlg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_queue
// Short command queue that decouples the front decoder from the back end.
// ----------------------------------------------------------------------------
module tlg_queue import tlg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      write,
  input  cmd_item_t write_item,
  output logic      full,
  input  logic      read,
  output cmd_item_t read_item,
  output logic      empty
);

  cmd_item_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign read_item = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (write) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (read)  rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (write && !read)      count <= count + 1'b1;
      else if (read && !write) count <= count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (write) slots[wr_ptr] <= write_item;
  end

endmodule

// ===== rtl/tlg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_back
// Turtle execution: pose, pose stack, registered trig of the heading and
// the segment output register.
// ----------------------------------------------------------------------------
module tlg_back import tlg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // command queue head
  input  logic         item_valid,
  input  cmd_item_t    item,
  // configuration
  input  logic [15:0]  turn_angle,
  input  logic [15:0]  step_length,
  input  logic [31:0]  origin_x,
  input  logic [31:0]  origin_y,
  input  logic [15:0]  origin_heading,
  // result channel
  output logic         out_valid,
  input  logic         out_ready,
  output logic [31:0]  seg_from_x,
  output logic [31:0]  seg_from_y,
  output logic [31:0]  seg_to_x,
  output logic [31:0]  seg_to_y,
  output logic         seg_fault,
  output back_status_t status
);

  // Pose and stack state
  logic [31:0]        pen_x;
  logic [31:0]        pen_y;
  logic [15:0]        pen_heading;
  logic [LEVEL_W-1:0] stack_level;
  logic               fault_seen;
  logic [31:0]        saved_x       [STACK_DEPTH];
  logic [31:0]        saved_y       [STACK_DEPTH];
  logic [15:0]        saved_heading [STACK_DEPTH];

  // Trig of the current heading and of the origin heading
  trig_t pen_cos;
  trig_t pen_sin;
  trig_t org_cos;
  trig_t org_sin;

  // Per-item working values
  logic               take;
  logic               emit;
  logic               push_en;
  logic [31:0]        base_x;
  logic [31:0]        base_y;
  logic [15:0]        base_heading;
  logic [LEVEL_W-1:0] base_level;
  logic               base_fault;
  trig_t              base_cos;
  trig_t              base_sin;
  logic [SIDX_W-1:0]  push_idx;
  logic [SIDX_W-1:0]  pop_idx;
  logic [LEVEL_W-1:0] level_dec;
  logic [31:0]        pen_x_next;
  logic [31:0]        pen_y_next;
  logic [15:0]        pen_heading_next;
  logic [LEVEL_W-1:0] stack_level_next;
  logic               fault_seen_next;

  // Step length times trig, rounded half away from zero, as a wrap delta
  function automatic logic [31:0] scaled_step(input logic [15:0] len, input trig_t t);
    logic [31:0] prod;
    logic [32:0] rnd;
    logic [31:0] mag;
    prod = 32'(len) * 32'(t.mag);
    rnd  = 33'(prod) + 33'(17'h04000);
    mag  = 32'(rnd[32:15]);
    return t.neg ? (32'd0 - mag) : mag;
  endfunction

  // Forward items wait for the output register, others never stall
  assign take = item_valid && (item.cmd != CMD_FORWARD || !out_valid || out_ready);

  // Restart selects the origin pose before the command is applied
  assign base_x       = item.restart ? origin_x       : pen_x;
  assign base_y       = item.restart ? origin_y       : pen_y;
  assign base_heading = item.restart ? origin_heading : pen_heading;
  assign base_level   = item.restart ? '0             : stack_level;
  assign base_fault   = item.restart ? 1'b0           : fault_seen;
  assign base_cos     = item.restart ? org_cos        : pen_cos;
  assign base_sin     = item.restart ? org_sin        : pen_sin;
  assign level_dec    = base_level - 1'b1;
  assign push_idx     = base_level[SIDX_W-1:0];
  assign pop_idx      = level_dec[SIDX_W-1:0];

  // Command execution
  always_comb begin
    pen_x_next       = pen_x;
    pen_y_next       = pen_y;
    pen_heading_next = pen_heading;
    stack_level_next = stack_level;
    fault_seen_next  = fault_seen;
    push_en          = 1'b0;
    emit             = 1'b0;
    if (take) begin
      pen_x_next       = base_x;
      pen_y_next       = base_y;
      pen_heading_next = base_heading;
      stack_level_next = base_level;
      fault_seen_next  = base_fault;
      unique case (item.cmd)
        CMD_TURN_POS: pen_heading_next = base_heading + turn_angle;
        CMD_TURN_NEG: pen_heading_next = base_heading - turn_angle;
        CMD_PUSH: begin
          if (base_level == LEVEL_W'(STACK_DEPTH)) begin
            fault_seen_next = 1'b1;
          end else begin
            push_en          = 1'b1;
            stack_level_next = base_level + 1'b1;
          end
        end
        CMD_POP: begin
          if (base_level == '0) begin
            fault_seen_next = 1'b1;
          end else begin
            stack_level_next = level_dec;
            pen_x_next       = saved_x[pop_idx];
            pen_y_next       = saved_y[pop_idx];
            pen_heading_next = saved_heading[pop_idx];
          end
        end
        CMD_FORWARD: begin
          emit       = 1'b1;
          pen_x_next = base_x + scaled_step(step_length, base_cos);
          pen_y_next = base_y + scaled_step(step_length, base_sin);
        end
        default: ;
      endcase
    end
  end

  // Pose, trig registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x       <= '0;
      pen_y       <= '0;
      pen_heading <= '0;
      stack_level <= '0;
      fault_seen  <= 1'b0;
      pen_cos     <= sine_lookup(QUARTER_TURN);
      pen_sin     <= sine_lookup(16'd0);
      org_cos     <= sine_lookup(QUARTER_TURN);
      org_sin     <= sine_lookup(16'd0);
      out_valid   <= 1'b0;
    end else begin
      pen_x       <= pen_x_next;
      pen_y       <= pen_y_next;
      pen_heading <= pen_heading_next;
      stack_level <= stack_level_next;
      fault_seen  <= fault_seen_next;
      pen_cos     <= sine_lookup(pen_heading_next + QUARTER_TURN);
      pen_sin     <= sine_lookup(pen_heading_next);
      org_cos     <= sine_lookup(origin_heading + QUARTER_TURN);
      org_sin     <= sine_lookup(origin_heading);
      if (emit)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Segment payload
  always_ff @(posedge clk) begin
    if (emit) begin
      seg_from_x <= base_x;
      seg_from_y <= base_y;
      seg_to_x   <= pen_x_next;
      seg_to_y   <= pen_y_next;
      seg_fault  <= fault_seen_next;
    end
  end

  // Pose stack
  always_ff @(posedge clk) begin
    if (push_en) begin
      saved_x[push_idx]       <= base_x;
      saved_y[push_idx]       <= base_y;
      saved_heading[push_idx] <= base_heading;
    end
  end

  assign status.level = stack_level;
  assign status.fault = fault_seen;
  assign status.take  = take;

endmodule

// ===== rtl/turtle_line_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turtle_line_generator
// Turtle graphics interpreter: one L-system symbol per item, one line
// segment per forward symbol.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------
//  input    | in_valid / in_ready    | symbol, restart
//  result   | out_valid / out_ready  | from_x, from_y, to_x, to_y, stack_fault
//  config   | cfg_write              | cfg_index, cfg_data
//
//  One item per cycle while no forward item holds at the queue head. An
//  item enters the two-entry command queue at acceptance and executes in
//  the back end once it reaches the queue head; a forward item's segment
//  is loaded into the output register at the edge that executes it. The
//  pose update (stack read, trig lookup, multiply and add) sets the rate. A
//  forward item at the queue head holds while the output register is full
//  and unread, and the items behind it wait; turns, pushes and pops at the
//  head never wait on it. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module turtle_line_generator import tlg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         symbol,
  input  logic               restart,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] from_x,
  output logic signed [31:0] from_y,
  output logic signed [31:0] to_x,
  output logic signed [31:0] to_y,
  output logic               stack_fault,
  // configuration
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // Configuration registers
  logic [15:0] turn_angle;
  logic [15:0] step_length;
  logic [31:0] origin_x;
  logic [31:0] origin_y;
  logic [15:0] origin_heading;

  // Queue interface
  logic         q_write;
  cmd_item_t    q_write_item;
  logic         q_full;
  logic         q_empty;
  cmd_item_t    q_head;
  back_status_t back_st;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_angle     <= TURN_ANGLE_RESET;
      step_length    <= STEP_LENGTH_RESET;
      origin_x       <= '0;
      origin_y       <= '0;
      origin_heading <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TURN_ANGLE:     turn_angle     <= cfg_data[15:0];
        REG_STEP_LENGTH:    step_length    <= cfg_data[15:0];
        REG_ORIGIN_X:       origin_x       <= cfg_data;
        REG_ORIGIN_Y:       origin_y       <= cfg_data;
        REG_ORIGIN_HEADING: origin_heading <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  tlg_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .symbol      (symbol),
    .restart     (restart),
    .queue_full  (q_full),
    .queue_write (q_write),
    .queue_item  (q_write_item)
  );

  tlg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .write      (q_write),
    .write_item (q_write_item),
    .full       (q_full),
    .read       (back_st.take),
    .read_item  (q_head),
    .empty      (q_empty)
  );

  tlg_back u_back (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (!q_empty),
    .item           (q_head),
    .turn_angle     (turn_angle),
    .step_length    (step_length),
    .origin_x       (origin_x),
    .origin_y       (origin_y),
    .origin_heading (origin_heading),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .seg_from_x     (from_x),
    .seg_from_y     (from_y),
    .seg_to_x       (to_x),
    .seg_to_y       (to_y),
    .seg_fault      (stack_fault),
    .status         (back_st)
  );

  // Stack level never passes the stack depth
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    back_st.level <= LEVEL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  // The fault flag clears only on reset or a restart item
  a_fault_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(back_st.fault) |-> ($past(rst) || ($past(back_st.take) && $past(q_head.restart))))
    else $error("fault flag cleared without restart");

  // The back end only executes items that are in the queue
  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    back_st.take |-> !q_empty)
    else $error("back end took from an empty queue");

  // A result only appears after the back end executed an item
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(back_st.take) && ($past(q_head.cmd) == CMD_FORWARD))
    else $error("result without a forward item");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the turtle line generator. Symbols stream in
// through a randomly paced handshake while a behavioral turtle (pose, pose
// stack, quarter-wave sine lookup) predicts every segment. The run steps
// through several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb;
  import tlg_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [31:0] from_x;
    logic [31:0] from_y;
    logic [31:0] to_x;
    logic [31:0] to_y;
    logic        fault;
  } segment_t;

  localparam int          CYCLE_LIMIT     = 400000;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          ITEMS_PER_PHASE = 135;
  localparam int          PHASES          = 7;
  localparam logic [2:0]  REG_UNUSED      = 3'd7;   // no register here
  localparam logic [15:0] MAX_16          = 16'hFFFF;

  // --------------------------------------------------------------------------
  // Turtle state tracker and segment scoreboard
  // --------------------------------------------------------------------------
  class turtle_tracker;
    logic [15:0] quarter_sine [QUARTER_N + 1];
    logic [15:0] turn_angle, step_length, origin_heading;
    logic [31:0] origin_x, origin_y;
    logic [31:0] pen_x, pen_y;
    logic [15:0] heading;
    logic [31:0] saved_x [STACK_DEPTH];
    logic [31:0] saved_y [STACK_DEPTH];
    logic [15:0] saved_heading [STACK_DEPTH];
    int          level;
    bit          fault;
    segment_t    segments_due [$];
    int          mismatches, segments_checked, overflows, underflows;

    function new();
      build_sine();
      turn_angle     = TURN_ANGLE_RESET;
      step_length    = STEP_LENGTH_RESET;
      origin_x       = '0;
      origin_y       = '0;
      origin_heading = '0;
      mismatches       = 0;
      segments_checked = 0;
      overflows        = 0;
      underflows       = 0;
      restart_pose();
    endfunction

    // Taylor series through x^17, Q30 sum rounded to Q15
    function void build_sine();
      u64_t x, term, acc;
      for (int k = 0; k <= QUARTER_N; k++) begin
        x    = (u64_t'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
        term = x;
        acc  = x;
        for (int n = 1; n <= 8; n++) begin
          term = (((term * x) >> 30) * x) >> 30;
          term = term / u64_t'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) acc = acc - term;
          else            acc = acc + term;
        end
        quarter_sine[k] = 16'((acc + 64'd16384) >> 15);
      end
    endfunction

    function void restart_pose();
      pen_x   = origin_x;
      pen_y   = origin_y;
      heading = origin_heading;
      level   = 0;
      fault   = 1'b0;
    endfunction

    // Signed Q1.15 sine of a binary angle
    function int signed_sine(logic [15:0] h);
      int idx, mag;
      idx = (int'(h[13:0]) + (1 << (13 - SINE_TABLE_BITS))) >> (14 - SINE_TABLE_BITS);
      mag = h[14] ? int'(quarter_sine[QUARTER_N - idx]) : int'(quarter_sine[idx]);
      return h[15] ? -mag : mag;
    endfunction

    // Step length times trig, magnitude rounded half away from zero
    function logic [31:0] step_delta(int trig);
      u64_t        mag;
      logic [31:0] d;
      mag = u64_t'((trig < 0) ? -trig : trig);
      d   = 32'((u64_t'(step_length) * mag + 64'd16384) >> 15);
      return (trig < 0) ? (32'd0 - d) : d;
    endfunction

    function void write_register(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_TURN_ANGLE:     turn_angle     = data[15:0];
        REG_STEP_LENGTH:    step_length    = data[15:0];
        REG_ORIGIN_X:       origin_x       = data;
        REG_ORIGIN_Y:       origin_y       = data;
        REG_ORIGIN_HEADING: origin_heading = data[15:0];
        default: ;
      endcase
    endfunction

    // Advance the turtle by one accepted item
    function void note_symbol(logic [7:0] sym, logic rs);
      segment_t    seg;
      logic [15:0] cos_angle;
      if (rs) restart_pose();
      case (sym)
        SYM_PLUS:  heading = heading + turn_angle;
        SYM_MINUS: heading = heading - turn_angle;
        SYM_PUSH: begin
          if (level >= STACK_DEPTH) begin
            fault = 1'b1;
            overflows++;
          end else begin
            saved_x[level]       = pen_x;
            saved_y[level]       = pen_y;
            saved_heading[level] = heading;
            level++;
          end
        end
        SYM_POP: begin
          if (level == 0) begin
            fault = 1'b1;
            underflows++;
          end else begin
            level--;
            pen_x   = saved_x[level];
            pen_y   = saved_y[level];
            heading = saved_heading[level];
          end
        end
        default: begin
          cos_angle  = heading + QUARTER_TURN;
          seg.from_x = pen_x;
          seg.from_y = pen_y;
          pen_x      = pen_x + step_delta(signed_sine(cos_angle));
          pen_y      = pen_y + step_delta(signed_sine(heading));
          seg.to_x   = pen_x;
          seg.to_y   = pen_y;
          seg.fault  = fault;
          segments_due.push_back(seg);
        end
      endcase
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_segment(segment_t got);
      segment_t want;
      if (segments_due.size() == 0) begin
        $display("%0t ns: segment expected none, got (%h,%h)->(%h,%h) fault %b",
                 $time, got.from_x, got.from_y, got.to_x, got.to_y, got.fault);
        mismatches++;
        return;
      end
      want = segments_due.pop_front();
      segments_checked++;
      check_field("from_x", want.from_x, got.from_x);
      check_field("from_y", want.from_y, got.from_y);
      check_field("to_x", want.to_x, got.to_x);
      check_field("to_y", want.to_y, got.to_y);
      check_field("stack_fault", 32'(want.fault), 32'(got.fault));
    endfunction

    function int pending();
      return segments_due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         symbol = '0;
  logic               restart = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] from_x, from_y, to_x, to_y;
  logic               stack_fault;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  turtle_tracker tracker;
  int            cycle_count = 0;
  int            symbols_sent = 0;
  int            settings_used = 1;
  bit            send_bursty = 1'b1;
  bit            recv_bursty = 1'b1;

  always #6 clk = ~clk;

  turtle_line_generator dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .symbol     (symbol),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .from_x     (from_x),
    .from_y     (from_y),
    .to_x       (to_x),
    .to_y       (to_y),
    .stack_fault(stack_fault),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d segments pending", cycle_count,
               tracker.pending());
      $display("[turtle_line_generator] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pick_forward();
    logic [7:0] s;
    do s = 8'($urandom_range(0, 255));
    while (s == SYM_PLUS || s == SYM_MINUS || s == SYM_PUSH || s == SYM_POP);
    return s;
  endfunction

  // One item on the input channel, random gap in front
  task automatic send_symbol(input logic [7:0] sym, input logic rs);
    int gap;
    gap = send_bursty ? $urandom_range(0, 13) : 0;
    if ($urandom_range(0, 39) == 0) send_bursty = !send_bursty;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    symbol   <= sym;
    restart  <= rs;
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.note_symbol(sym, rs);
    symbols_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.write_register(idx, data);
  endtask

  // Hold off input until every segment is back, then let the pipe empty
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: random stalls, check each accepted segment
  initial begin
    int       stall;
    segment_t got;
    wait (rst == 1'b0);
    forever begin
      stall = recv_bursty ? $urandom_range(0, 13) : 0;
      if ($urandom_range(0, 39) == 0) recv_bursty = !recv_bursty;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.from_x = from_x;
      got.from_y = from_y;
      got.to_x   = to_x;
      got.to_y   = to_y;
      got.fault  = stack_fault;
      tracker.check_segment(got);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int          r, burst, gen_depth;
    logic [7:0]  sym;
    logic        rs;
    logic [15:0] ta, sl, oh;
    logic [31:0] ox, oy;

    tracker = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, field extremes, every symbol class,
    // underflow, fault clear on restart, overflow
    send_symbol(8'h00, 1'b1);
    send_symbol(SYM_PLUS, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(SYM_MINUS, 1'b0);
    send_symbol(SYM_PUSH, 1'b0);
    send_symbol(pick_forward(), 1'b0);
    send_symbol(SYM_POP, 1'b0);
    send_symbol(pick_forward(), 1'b0);
    send_symbol(SYM_POP, 1'b0);          // empty stack
    send_symbol(pick_forward(), 1'b0);   // fault now visible
    send_symbol(SYM_PLUS, 1'b1);         // restart on a turn clears it
    send_symbol(pick_forward(), 1'b0);
    repeat (STACK_DEPTH + 1) send_symbol(SYM_PUSH, 1'b0);
    send_symbol(pick_forward(), 1'b0);

    for (int phase = 1; phase <= PHASES; phase++) begin
      drain_and_settle();

      // Register setting for this phase
      ta = 16'($urandom);
      sl = 16'($urandom);
      ox = $urandom;
      oy = $urandom;
      oh = 16'($urandom);
      case (phase)
        1: begin
          ta = QUARTER_TURN;  sl = MAX_16;
          ox = 32'h7FFF_FF00; oy = 32'h8000_0000; oh = QUARTER_TURN;
        end
        2: begin
          ta = '0;            sl = '0;
          ox = 32'h8000_0000; oy = 32'h7FFF_FFFF; oh = MAX_16;
        end
        3: begin
          ta = MAX_16; sl = 16'd1; oh = '0;
        end
        4: sl = MAX_16;
        5: begin
          ox = '0; oy = '0;
        end
        default: ;
      endcase
      write_reg(REG_TURN_ANGLE, {16'($urandom), ta});
      write_reg(REG_STEP_LENGTH, {16'($urandom), sl});
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_ORIGIN_HEADING, {16'($urandom), oh});
      if (phase == 2) write_reg(REG_UNUSED, $urandom);
      cfg_write <= 1'b0;
      settings_used++;

      // Mostly nested bracket strings, some noise and deep push runs
      gen_depth = 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        rs = (i == 0) || ($urandom_range(0, 63) == 0);
        if (rs) gen_depth = 0;
        r = $urandom_range(0, 99);
        if (r < 8) begin
          sym = 8'($urandom_range(0, 255));
        end else if (r < 10 && gen_depth < 4) begin
          burst = STACK_DEPTH + $urandom_range(0, 3) - gen_depth;
          repeat (burst) begin
            send_symbol(SYM_PUSH, rs);
            rs = 1'b0;
          end
          gen_depth += burst;
          sym = pick_forward();
        end else if (r < 32) begin
          sym = pick_forward();
        end else if (r < 45) begin
          sym = SYM_PLUS;
        end else if (r < 58) begin
          sym = SYM_MINUS;
        end else if (r < 78) begin
          sym = SYM_PUSH;
          gen_depth++;
        end else if (gen_depth > 0) begin
          sym = SYM_POP;
          gen_depth--;
        end else begin
          sym = pick_forward();
        end
        send_symbol(sym, rs);
      end
    end

    drain_and_settle();
    $display("Ran %0d symbols over %0d register settings; %0d segments checked,",
             symbols_sent, settings_used, tracker.segments_checked);
    $display("%0d stack overflows and %0d underflows exercised.",
             tracker.overflows, tracker.underflows);
    if (tracker.mismatches == 0) begin
      $display("[turtle_line_generator] OK");
    end else begin
      $display("%0d mismatches", tracker.mismatches);
      $display("[turtle_line_generator] ERROR");
    end
    $finish;
  end

endmodule
